/* hw/rtl/rgbmf_pkg.sv */
// Package for the 5x5 RGB median filter: window geometry, sort network sizes,
// register indexes and the comparator placement function of the merge network.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rgbmf_pkg;

    localparam int WIN         = 5;
    localparam int HALO        = WIN - 1;
    localparam int TAPS        = WIN * WIN;
    localparam int MEDIAN_IDX  = TAPS / 2;
    localparam int SORT_LOG    = 5;                              // network padded to 32
    localparam int SORT_STAGES = SORT_LOG * (SORT_LOG + 1) / 2;
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int LINE_BUS_W  = HALO * PIX_W;
    localparam int MAX_LINE    = 2048;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int LW_W        = 14;                             // wide enough for any clamp
    localparam int ROW_W       = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd2;

    localparam logic [11:0] LINE_WIDTH_RST = 12'd2048;
    localparam logic [10:0] OUT_WIDTH_RST  = 11'd2044;
    localparam logic [12:0] OUT_HEIGHT_RST = 13'd1;

    typedef logic [2:0][TAPS-1:0][CH_W-1:0] sort_vec_t;

    // True when index lo is the low side of a comparator in merge step
    // p = 2**lp, k = 2**lk. Comparators reaching the padding are pruned.
    function automatic logic cmp_en(int lp, int lk, int lo);
        int  k;
        int  off;
        logic r;
        k   = 1 << lk;
        off = (lk < lp) ? k : 0;
        r   = 1'b0;
        if (lo >= off && lo + k < TAPS) begin
            if (((lo - off) & (2 * k - 1)) < k)
                r = ((lo >> (lp + 1)) == ((lo + k) >> (lp + 1)));
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/rgbmf_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rgbmf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* hw/rtl/rgb_median_filter_5x5.sv */
// 5x5 RGB median filter: line store RAM, window registers, pipelined
// odd-even merge sort network. Depends on rgbmf_pkg and rgbmf_ram.
//
// Usage: feed the border-extended frame one pixel per transfer on s_axis
// (s_tdata = red, green, blue from bit 0), raster order, line_width pixels per
// row and out_height+4 rows. Each output position gives one transfer on
// m_axis with the three channel medians; m_tlast marks the last of a frame.
// Pixels in columns at or past out_width+4 are counted but otherwise dropped.
// Throughput: one pixel per cycle sustained while m_tready is high; the line
// store RAM is read once and written once per pixel, and the sort network has a
// register after every merge step.
// Pipeline: the input transfer starts the RAM read and registers the pixel,
// then comes the window update, then 15 sort steps; the last step is the output
// register.
// Stalls: when m_tready is low, results pile up in the pipeline stages; s_tready
// drops only once every stage holds an item. No data is lost.
// Reset: counters go to zero and registers to line_width 2048, out_width 2044,
// out_height 1. Line store contents are not cleared; they are written by the
// first four rows before any result depends on them.
// Config: cfg_wr_en writes cfg_data to register cfg_index (0 line_width,
// 1 out_width, 2 out_height); write only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module rgb_median_filter_5x5 #(
    parameter int MAX_LINE = rgbmf_pkg::MAX_LINE
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [rgbmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rgbmf_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,   // red_in, green_in, blue_in
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [23:0]                         m_tdata,   // red_median, green_median, blue_median
    output logic                                m_tlast    // frame_end
);

    localparam int AW    = $clog2(MAX_LINE);
    localparam int COL_W = (AW > 12) ? AW : 12;
    localparam int NS    = rgbmf_pkg::SORT_STAGES;
    localparam int TAPS  = rgbmf_pkg::TAPS;
    localparam int PW    = rgbmf_pkg::PIX_W;
    localparam int CW    = rgbmf_pkg::CH_W;
    localparam int LW_W  = rgbmf_pkg::LW_W;
    localparam int ROW_W = rgbmf_pkg::ROW_W;
    localparam int HALO  = rgbmf_pkg::HALO;

    // configuration
    logic [11:0] line_width_reg;
    logic [10:0] out_width_reg;
    logic [12:0] out_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= rgbmf_pkg::LINE_WIDTH_RST;
            out_width_reg  <= rgbmf_pkg::OUT_WIDTH_RST;
            out_height_reg <= rgbmf_pkg::OUT_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rgbmf_pkg::CFG_LINE_WIDTH: line_width_reg <= cfg_data[11:0];
                rgbmf_pkg::CFG_OUT_WIDTH:  out_width_reg  <= cfg_data[10:0];
                rgbmf_pkg::CFG_OUT_HEIGHT: out_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [LW_W-1:0]  lw_eff, ow_max, ow_eff, ow_lim;
    logic [ROW_W-1:0] rows;

    always_comb begin
        if (line_width_reg < 12'(rgbmf_pkg::WIN))
            lw_eff = LW_W'(rgbmf_pkg::WIN);
        else if (LW_W'(line_width_reg) > LW_W'(MAX_LINE))
            lw_eff = LW_W'(MAX_LINE);
        else
            lw_eff = LW_W'(line_width_reg);
        ow_max = lw_eff - LW_W'(HALO);
        if (out_width_reg == 11'd0)
            ow_eff = LW_W'(1);
        else if (LW_W'(out_width_reg) > ow_max)
            ow_eff = ow_max;
        else
            ow_eff = LW_W'(out_width_reg);
        ow_lim = ow_eff + LW_W'(HALO);
        rows   = ((out_height_reg == 13'd0) ? ROW_W'(1) : ROW_W'(out_height_reg))
                 + ROW_W'(HALO);
    end

    // position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [LW_W-1:0]  col_x;
    logic             in_xfer, in_store, in_emit, in_fe;

    assign col_x    = LW_W'(col_reg);
    assign in_xfer  = s_tvalid && s_tready;
    assign in_store = col_x < ow_lim;
    assign in_emit  = in_store && (row_reg >= ROW_W'(HALO)) && (row_reg < rows)
                      && (col_x >= LW_W'(HALO));
    assign in_fe    = (row_reg == rows - ROW_W'(1)) && (col_x == ow_lim - LW_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (in_xfer) begin
            if (col_x + LW_W'(1) >= lw_eff) begin
                col_reg <= '0;
                row_reg <= (row_reg + ROW_W'(1) >= rows) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // stage 1: line store read in flight
    logic              s1_valid_reg, s1_emit_reg, s1_fe_reg;
    logic [PW-1:0]     s1_pix_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [rgbmf_pkg::LINE_BUS_W-1:0] line_rd;
    logic              s1_adv, w_free;
    logic              w_valid_reg, w_fe_reg;
    logic [PW-1:0]     win_reg [TAPS];
    logic [NS:0]       rs;
    logic [NS-1:0]     st_valid_reg, st_fe_reg;
    rgbmf_pkg::sort_vec_t sd_reg [NS];
    rgbmf_pkg::sort_vec_t sin    [NS];
    rgbmf_pkg::sort_vec_t nx     [NS];

    assign w_free   = !w_valid_reg || rs[0];
    assign s1_adv   = s1_valid_reg && w_free;
    assign s_tready = !s1_valid_reg || s1_adv;

    rgbmf_ram #(
        .WIDTH (rgbmf_pkg::LINE_BUS_W),
        .DEPTH (MAX_LINE)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data ({s1_pix_reg, line_rd[rgbmf_pkg::LINE_BUS_W-1:PW]}),
        .rd_en   (in_xfer && in_store),
        .rd_addr (col_reg[AW-1:0]),
        .rd_data (line_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= in_xfer && in_store;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_tready) begin
            s1_pix_reg  <= s_tdata;
            s1_addr_reg <= col_reg[AW-1:0];
            s1_emit_reg <= in_emit;
            s1_fe_reg   <= in_fe;
        end
    end

    // window: shift left, new column from the line store and the new pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            w_valid_reg <= s1_emit_reg;
        end else if (rs[0]) begin
            w_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            w_fe_reg <= s1_fe_reg;
            for (int y = 0; y < rgbmf_pkg::WIN; y++) begin
                for (int x = 0; x < rgbmf_pkg::WIN - 1; x++)
                    win_reg[y * rgbmf_pkg::WIN + x] <= win_reg[y * rgbmf_pkg::WIN + x + 1];
            end
            for (int y = 0; y < HALO; y++)
                win_reg[y * rgbmf_pkg::WIN + rgbmf_pkg::WIN - 1] <= line_rd[y * PW +: PW];
            win_reg[TAPS - 1] <= s1_pix_reg;
        end
    end

    // sort pipeline handshake
    always_comb begin
        rs[NS] = m_tready;
        for (int s = NS - 1; s >= 0; s--)
            rs[s] = !st_valid_reg[s] || rs[s + 1];
    end

    genvar gc, gi, gp, gk, gl;
    generate
        for (gc = 0; gc < 3; gc++) begin : g_win_ch
            for (gi = 0; gi < TAPS; gi++) begin : g_win_tap
                assign sin[0][gc][gi] = win_reg[gi][gc * CW +: CW];
            end
        end
        for (gi = 1; gi < NS; gi++) begin : g_sin
            assign sin[gi] = sd_reg[gi - 1];
        end
        for (gp = 0; gp < rgbmf_pkg::SORT_LOG; gp++) begin : g_p
            for (gk = gp; gk >= 0; gk--) begin : g_k
                localparam int S = gp * (gp + 1) / 2 + (gp - gk);
                localparam int K = 1 << gk;
                for (gc = 0; gc < 3; gc++) begin : g_ch
                    for (gl = 0; gl < TAPS; gl++) begin : g_lo
                        if (rgbmf_pkg::cmp_en(gp, gk, gl)) begin : g_cmp
                            logic lt;
                            assign lt = sin[S][gc][gl] <= sin[S][gc][gl + K];
                            assign nx[S][gc][gl]     = lt ? sin[S][gc][gl] : sin[S][gc][gl + K];
                            assign nx[S][gc][gl + K] = lt ? sin[S][gc][gl + K] : sin[S][gc][gl];
                        end else if (!(gl >= K && rgbmf_pkg::cmp_en(gp, gk, gl - K))) begin : g_pass
                            assign nx[S][gc][gl] = sin[S][gc][gl];
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (rs[s])
                    st_valid_reg[s] <= (s == 0) ? w_valid_reg : st_valid_reg[s - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NS; s++) begin
            if (rs[s]) begin
                sd_reg[s]    <= nx[s];
                st_fe_reg[s] <= (s == 0) ? w_fe_reg : st_fe_reg[s - 1];
            end
        end
    end

    assign m_tvalid = st_valid_reg[NS - 1];
    assign m_tlast  = st_fe_reg[NS - 1];
    assign m_tdata  = {sd_reg[NS - 1][2][rgbmf_pkg::MEDIAN_IDX],
                       sd_reg[NS - 1][1][rgbmf_pkg::MEDIAN_IDX],
                       sd_reg[NS - 1][0][rgbmf_pkg::MEDIAN_IDX]};

endmodule
`default_nettype wire
